/* src/ccpc_pkg.sv */
package ccpc_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int QR_STEPS = DOUBLE_ROUNDS * 8;
  localparam int QR_W = $clog2(QR_STEPS + 1);
  localparam logic [QR_W-1:0] QR_LAST = QR_W'(QR_STEPS - 1);

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [63:0] MIX_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_LANE = 64'hD6E8FEB86659FD93;
  localparam logic [63:0] MIX_LANE2 = MIX_LANE * 64'd2;
  localparam logic [63:0] MIX_LANE3 = MIX_LANE * 64'd3;
  localparam logic [63:0] MIX_LANE4 = MIX_LANE * 64'd4;
  localparam logic [7:0] TAG_L = 8'h4C;
  localparam logic [7:0] TAG_R = 8'h52;

  localparam logic [0:0] REG_KEY_SEED = 1'b0;
  localparam logic [0:0] REG_DECRYPT = 1'b1;

  localparam logic [3:0] ADDR_KEY_SEED = 4'd0;
  localparam logic [3:0] ADDR_DECRYPT = 4'd8;

  function automatic logic [63:0] seed_mix(input logic [1:0] i);
    logic [63:0] r;
    begin
      case (i)
        2'd0: r = 64'h0;
        2'd1: r = 64'h6170786512345678;
        2'd2: r = 64'h3320646e99887766;
        default: r = 64'h79622d3276543210;
      endcase
      return r;
    end
  endfunction

  // Lane constant (i + 1) * MIX_LANE, taken from a table of four constants.
  function automatic logic [63:0] lane_mix(input logic [1:0] i);
    logic [63:0] r;
    begin
      case (i)
        2'd0: r = MIX_LANE;
        2'd1: r = MIX_LANE2;
        2'd2: r = MIX_LANE3;
        default: r = MIX_LANE4;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Word indices a,b,c,d of quarter round q (0..7) within one double round.
  function automatic logic [15:0] qr_idx(input logic [2:0] q);
    logic [15:0] r;
    begin
      case (q)
        3'd0: r = {4'd0, 4'd4, 4'd8, 4'd12};
        3'd1: r = {4'd1, 4'd5, 4'd9, 4'd13};
        3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
        3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
        3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
        3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
        3'd6: r = {4'd2, 4'd7, 4'd8, 4'd13};
        default: r = {4'd3, 4'd4, 4'd9, 4'd14};
      endcase
      return r;
    end
  endfunction

endpackage

/* src/ccpc_if.sv */
interface ccpc_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] byte_in;
  logic [31:0] pkt_seq;
  logic [7:0] packet_length;
  modport source (output valid, byte_in, pkt_seq, packet_length, input ready);
  modport sink (input valid, byte_in, pkt_seq, packet_length, output ready);
endinterface

interface ccpc_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] byte_out;
  logic last_of_packet;
  modport source (output valid, byte_out, last_of_packet, input ready);
  modport sink (input valid, byte_out, last_of_packet, output ready);
endinterface

/* src/ccpc_qr.sv */
// Shared quarter-round unit: one full quarter round per cycle on 16 words.
module ccpc_qr (
  input  logic [31:0] w_in [16],
  input  logic [2:0]  q,
  output logic [31:0] w_out [16]
);
  logic [15:0] ix;
  logic [3:0] ia, ib, ic, id;
  logic [31:0] a, b, c, d;

  always_comb begin
    ix = ccpc_pkg::qr_idx(q);
    ia = ix[15:12];
    ib = ix[11:8];
    ic = ix[7:4];
    id = ix[3:0];
    a = w_in[ia];
    b = w_in[ib];
    c = w_in[ic];
    d = w_in[id];
    a = a + b; d = ccpc_pkg::rol32(d ^ a, 16);
    c = c + d; b = ccpc_pkg::rol32(b ^ c, 12);
    a = a + b; d = ccpc_pkg::rol32(d ^ a, 8);
    c = c + d; b = ccpc_pkg::rol32(b ^ c, 7);
    w_out = w_in;
    w_out[ia] = a;
    w_out[ib] = b;
    w_out[ic] = c;
    w_out[id] = d;
  end
endmodule

/* src/chacha20_packet_crypt_top.sv */
// Byte-serial ChaCha20 packet cipher.
// in_ch takes one word per packet byte: byte_in, plus pkt_seq and packet_length,
// which are sampled on the first byte of a packet only. out_ch returns one word
// per input word, in order: byte_out and last_of_packet. Valid/ready on both.
// The APB port holds key_seed at byte address 0 and decrypt_mode at address 8
// (64-bit data, pready tied high). Both are sampled while a packet's first byte
// is processed; write them only while no word is in flight.
// One word at a time: the input is not ready until the result has been taken.
// First byte of a packet: the key is expanded (four lanes, each three 32x32
// partial products and a closing step), the state is loaded, DOUBLE_ROUNDS*8
// quarter rounds run through the shared quarter-round unit and the initial state
// words are added. Bytes 1, 65, 129 and 193 start a new keystream block: they skip
// the key expansion. Other bytes: the result is registered on acceptance and
// is valid in the next cycle. The input is ready again in the cycle after the
// result is taken.
// Reset clears the APB registers, the expanded key and the packet context, and
// waits for a packet's first byte.
// A stalled receiver holds the result register and keeps the input not ready.
module chacha20_packet_crypt_top (
  input  logic        clk,
  input  logic        rst,
  ccpc_in_if.sink     in_ch,
  ccpc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_INIT  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [63:0] key_seed;
  logic decrypt_mode;
  logic [63:0] expanded_key [4];
  logic [31:0] ks [16];
  logic [31:0] w [16];
  logic [31:0] w_qr [16];
  logic [31:0] init_w [16];
  logic [7:0] byte_position, held_length, first_plain_byte, cur_byte;
  logic [31:0] held_pkt_seq;
  logic [1:0] block_index;
  logic first_blk;
  logic [ccpc_pkg::QR_W-1:0] step;
  logic [3:0] kcnt;
  logic [63:0] kx, kacc;
  logic [63:0] pp;
  logic [7:0] out_byte;
  logic out_last;
  logic [5:0] off;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3])
      ccpc_pkg::REG_KEY_SEED: prdata = key_seed;
      ccpc_pkg::REG_DECRYPT: prdata = {63'd0, decrypt_mode};
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.byte_out = out_byte;
  assign out_ch.last_of_packet = out_last;

  ccpc_qr u_qr (.w_in(w), .q(step[2:0]), .w_out(w_qr));

  always_comb begin
    init_w[0] = ccpc_pkg::SIGMA0; init_w[1] = ccpc_pkg::SIGMA1;
    init_w[2] = ccpc_pkg::SIGMA2; init_w[3] = ccpc_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = expanded_key[i][31:0];
      init_w[5 + 2 * i] = expanded_key[i][63:32];
    end
    init_w[12] = {30'd0, first_blk ? 2'd0 : block_index};
    init_w[13] = held_pkt_seq;
    init_w[14] = {ccpc_pkg::TAG_R, ccpc_pkg::TAG_L, held_length,
                  first_blk ? 8'd0 : first_plain_byte};
    init_w[15] = 32'd0;
  end

  // Key lane: kcnt[3:2] lane, kcnt[1:0] partial product (a_i * b_j, i+j<2).
  always_comb begin
    logic [31:0] pa, pb;
    pa = kcnt[1] ? kx[63:32] : kx[31:0];
    pb = kcnt[0] ? ccpc_pkg::MIX_MUL[63:32] : ccpc_pkg::MIX_MUL[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
  end

  assign off = byte_position[5:0] - 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key_seed <= '0;
      decrypt_mode <= 1'b0;
      byte_position <= '0;
      held_pkt_seq <= '0;
      held_length <= '0;
      first_plain_byte <= '0;
      block_index <= '0;
      for (int i = 0; i < 4; i++) expanded_key[i] <= '0;
      first_blk <= 1'b0;
      step <= '0;
      kcnt <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3])
          ccpc_pkg::REG_KEY_SEED: key_seed <= pwdata;
          ccpc_pkg::REG_DECRYPT: decrypt_mode <= pwdata[0];
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          cur_byte <= in_ch.byte_in;
          if (byte_position == 8'd0) begin
            held_pkt_seq <= in_ch.pkt_seq;
            held_length <= in_ch.packet_length;
            first_blk <= 1'b1;
            kcnt <= '0;
            kx <= key_seed ^ ccpc_pkg::seed_mix(2'd0);
            kacc <= '0;
            state <= S_KEY;
          end else if (off == 6'd0) begin
            first_blk <= 1'b0;
            block_index <= 2'(byte_position - 8'd1 >> 6);
            state <= S_INIT;
          end else begin
            out_byte <= in_ch.byte_in ^ ks[off[5:2]][{off[1:0], 3'b000} +: 8];
            out_last <= (9'(byte_position) + 9'd1 >= 9'(held_length));
            byte_position <= (9'(byte_position) + 9'd1 >= 9'(held_length))
                             ? 8'd0 : byte_position + 8'd1;
            state <= S_OUT;
          end
        end
        S_KEY: begin
          // partial products: 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 skip (beyond 64 bits)
          case (kcnt[1:0]) inside
            2'd0: kacc <= pp;
            [2'd1:2'd2]: kacc <= kacc + {pp[31:0], 32'd0};
            default: begin
              expanded_key[kcnt[3:2]] <= kacc ^ {32'd0, kx[63:32]} ^
                  ccpc_pkg::lane_mix(kcnt[3:2]);
              kx <= key_seed ^ ccpc_pkg::seed_mix(kcnt[3:2] + 2'd1);
            end
          endcase
          kcnt <= kcnt + 4'd1;
          if (kcnt == 4'd15) state <= S_INIT;
        end
        S_INIT: begin
          w <= init_w;
          step <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          w <= w_qr;
          step <= step + 1'b1;
          if (step == ccpc_pkg::QR_LAST) state <= S_FIN;
        end
        S_FIN: begin
          logic [7:0] ks0, res;
          logic lst;
          for (int i = 0; i < 16; i++) ks[i] <= w[i] + init_w[i];
          ks0 = 8'(w[0] + init_w[0]);
          res = cur_byte ^ ks0;
          out_byte <= res;
          if (first_blk) begin
            lst = (held_length <= 8'd1);
            first_plain_byte <= decrypt_mode ? res : cur_byte;
            block_index <= 2'd0;
          end else begin
            lst = (9'(byte_position) + 9'd1 >= 9'(held_length));
          end
          out_last <= lst;
          byte_position <= lst ? 8'd0 : byte_position + 8'd1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The multiply-xor wraps at 64 bits: only lo*lo, lo*hi, hi*lo contribute.
  // Shift term of the mix was folded in at lane close.

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_ch.ready) |=> (state == S_OUT && $stable(out_byte)))
    else $error("result changed while stalled");
  a_nin: assert property (@(posedge clk) disable iff (rst)
    (in_ch.ready && in_ch.valid) |=> !in_ch.ready)
    else $error("accepted twice");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_last) |-> byte_position == 8'd0)
    else $error("position not cleared at end of packet");
endmodule

/* sim/chacha20_packet_crypt_top_test.sv */
module chacha20_packet_crypt_top_test;

  localparam int RUN_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_packet;
  } cipher_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  ccpc_in_if in_ch (clk);
  ccpc_out_if out_ch (clk);

  chacha20_packet_crypt_top u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Predictor state: shadow registers and the cipher's packet context.
  logic [63:0] shadow_seed;
  logic        shadow_decrypt;
  logic [63:0] cipher_key [4];
  logic [7:0]  key_stream [64];
  logic [31:0] mix_words [16];
  logic [7:0]  pkt_pos;
  logic [31:0] pkt_number;
  logic [7:0]  pkt_length;
  logic [7:0]  pkt_first_plain;

  cipher_word_t pending_words[$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  // Drive every block input to a known value from time zero.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.pkt_seq = '0;
    in_ch.packet_length = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void quarter_mix(input int a, input int b, input int c, input int d);
    mix_words[a] += mix_words[b]; mix_words[d] = rotl(mix_words[d] ^ mix_words[a], 16);
    mix_words[c] += mix_words[d]; mix_words[b] = rotl(mix_words[b] ^ mix_words[c], 12);
    mix_words[a] += mix_words[b]; mix_words[d] = rotl(mix_words[d] ^ mix_words[a], 8);
    mix_words[c] += mix_words[d]; mix_words[b] = rotl(mix_words[b] ^ mix_words[c], 7);
  endfunction

  // Fill key_stream with one ChaCha block; salt is nonce byte 4.
  function automatic void build_block(input logic [31:0] counter, input logic [7:0] salt);
    logic [31:0] init [16];
    logic [31:0] v;
    init[0] = ccpc_pkg::SIGMA0; init[1] = ccpc_pkg::SIGMA1;
    init[2] = ccpc_pkg::SIGMA2; init[3] = ccpc_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = cipher_key[i][31:0];
      init[5 + 2 * i] = cipher_key[i][63:32];
    end
    init[12] = counter;
    init[13] = pkt_number;
    init[14] = {ccpc_pkg::TAG_R, ccpc_pkg::TAG_L, pkt_length, salt};
    init[15] = '0;
    for (int i = 0; i < 16; i++) mix_words[i] = init[i];
    for (int r = 0; r < ccpc_pkg::DOUBLE_ROUNDS; r++) begin
      quarter_mix(0, 4, 8, 12);  quarter_mix(1, 5, 9, 13);
      quarter_mix(2, 6, 10, 14); quarter_mix(3, 7, 11, 15);
      quarter_mix(0, 5, 10, 15); quarter_mix(1, 6, 11, 12);
      quarter_mix(2, 7, 8, 13);  quarter_mix(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      v = mix_words[i] + init[i];
      for (int k = 0; k < 4; k++) key_stream[4 * i + k] = v[8 * k +: 8];
    end
  endfunction

  function automatic cipher_word_t cipher_byte(input logic [7:0] b, input logic [31:0] pn,
                                               input logic [7:0] len);
    cipher_word_t r;
    logic [63:0] lane_seed [4];
    logic [63:0] w;
    logic [7:0] off;
    lane_seed[0] = 64'h0;
    lane_seed[1] = 64'h6170786512345678;
    lane_seed[2] = 64'h3320646e99887766;
    lane_seed[3] = 64'h79622d3276543210;
    if (pkt_pos == 8'd0) begin
      pkt_number = pn;
      pkt_length = len;
      for (int i = 0; i < 4; i++) begin
        w = shadow_seed ^ lane_seed[i];
        w = (w * ccpc_pkg::MIX_MUL) ^ (w >> 32);
        w ^= 64'(i + 1) * ccpc_pkg::MIX_LANE;
        cipher_key[i] = w;
      end
      build_block(32'd0, 8'd0);
      r.byte_out = b ^ key_stream[0];
      pkt_first_plain = shadow_decrypt ? r.byte_out : b;
      // a zero length behaves as a one-byte packet
      r.last_of_packet = (pkt_length <= 8'd1);
      pkt_pos = r.last_of_packet ? 8'd0 : 8'd1;
    end else begin
      off = pkt_pos - 8'd1;
      if (off[5:0] == 6'd0) build_block({30'd0, off[7:6]}, pkt_first_plain);
      r.byte_out = b ^ key_stream[off[5:0]];
      r.last_of_packet = ({1'b0, pkt_pos} + 9'd1 >= {1'b0, pkt_length});
      pkt_pos = r.last_of_packet ? 8'd0 : pkt_pos + 8'd1;
    end
    return r;
  endfunction

  // Cycle limit: abort the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("chacha20_packet_crypt_top_test failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted down in its own process.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Check each accepted output word against the oldest expectation, then pick
  // the next ready value.
  always @(posedge clk) begin
    cipher_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected word: byte_out=%h last=%b", out_ch.byte_out,
                   out_ch.last_of_packet);
      end else begin
        want = pending_words.pop_front();
        if (out_ch.byte_out !== want.byte_out ||
            out_ch.last_of_packet !== want.last_of_packet) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected byte_out=%h last=%b, got byte_out=%h last=%b",
                     want.byte_out, want.last_of_packet, out_ch.byte_out,
                     out_ch.last_of_packet);
        end
      end
    end
    if (hold_off_cycles > 0) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  task automatic send_word(input logic [7:0] b, input logic [31:0] pn, input logic [7:0] len);
    // idle the sender before the word, at random
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_in <= b;
    in_ch.pkt_seq <= pn;
    in_ch.packet_length <= len;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_words.push_back(cipher_byte(b, pn, len));
  endtask

  // Drop valid and let the block drain completely.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ccpc_pkg::ADDR_KEY_SEED) shadow_seed = value;
    else if (addr == ccpc_pkg::ADDR_DECRYPT) shadow_decrypt = value[0];
  endtask

  // Send one packet; bytes after the first carry noise in the ignored fields.
  task automatic send_packet(input int len, input logic [31:0] pn, input int fill);
    int n;
    logic [7:0] b;
    n = (len == 0) ? 1 : len;
    for (int i = 0; i < n; i++) begin
      case (fill)
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      if (i == 0) send_word(b, pn, 8'(len));
      else send_word(b, $urandom, 8'($urandom));
    end
  endtask

  task automatic test_reset_key();
    send_packet(1, 32'h0, 0);
    send_packet(0, 32'hFFFF_FFFF, 1);
    send_packet(2, 32'h1234_5678, 2);
    send_packet(3, 32'hFFFF_FFFF, 1);
  endtask

  task automatic test_extreme_config();
    drain_block();
    write_reg(ccpc_pkg::ADDR_KEY_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ccpc_pkg::ADDR_DECRYPT, 64'd1);
    send_packet(1, 32'h0, 1);
    send_packet(4, 32'hFFFF_FFFF, 0);
    drain_block();
    write_reg(ccpc_pkg::ADDR_DECRYPT, 64'd0);
    send_packet(0, 32'h8000_0001, 2);
    send_packet(5, 32'hA5A5_5A5A, 2);
  endtask

  // Fill the block while the receiver is held off, then stop until drained.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 400;
    send_packet(40, $urandom, 2);
    drain_block();
  endtask

  task automatic test_random_packets(input int budget);
    int sent;
    int len;
    int phase;
    logic [63:0] seed;
    sent = 0;
    phase = 0;
    while (sent < budget) begin
      drain_block();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case ($urandom_range(5, 0))
        0: seed = 64'h0;
        1: seed = 64'hFFFF_FFFF_FFFF_FFFF;
        default: seed = {$urandom, $urandom};
      endcase
      write_reg(ccpc_pkg::ADDR_KEY_SEED, seed);
      write_reg(ccpc_pkg::ADDR_DECRYPT, 64'($urandom_range(1, 0)));
      for (int p = 0; p < 12 && sent < budget; p++) begin
        len = ($urandom_range(14, 0) == 0) ? $urandom_range(255, 21) : $urandom_range(20, 0);
        send_packet(len, $urandom, 2);
        sent += (len == 0) ? 1 : len;
      end
      phase++;
    end
  endtask

  initial begin
    shadow_seed = '0;
    shadow_decrypt = 1'b0;
    for (int i = 0; i < 4; i++) cipher_key[i] = '0;
    pkt_pos = '0;
    pkt_number = '0;
    pkt_length = '0;
    pkt_first_plain = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_extreme_config();
    test_backpressure();
    test_random_packets(1750);
    drain_block();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("chacha20_packet_crypt_top_test passed");
    end else begin
      $display("chacha20_packet_crypt_top_test failed");
    end
    $finish;
  end

endmodule
